FILE: hw/rtl/cfpq_pkg.sv
// cfpq_pkg: shared constants, types and helper functions for the class fifo priority queue
// used by cfpq_ctrl, cfpq_datapath and class_fifo_priority_queue_unit
// no dependencies
package cfpq_pkg;

   localparam int NUM_CLASSES = 8;
   localparam int CLASS_DEPTH = 16;
   localparam int DATA_WIDTH  = 32;

   localparam int STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;
   localparam int CLS_W       = $clog2(NUM_CLASSES);
   localparam int PTR_W       = $clog2(CLASS_DEPTH);
   localparam int FILL_W      = $clog2(CLASS_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);

   // port field widths
   localparam int MODE_FW   = 1;
   localparam int CLASS_FW  = 3;
   localparam int DATA_FW   = 32;
   localparam int STATUS_FW = 2;
   localparam int COUNT_FW  = 8;

   localparam logic [MODE_FW-1:0] MODE_INSERT = 1'b0;
   localparam logic [MODE_FW-1:0] MODE_REMOVE = 1'b1;

   localparam logic [STATUS_FW-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_FW-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_FW-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [0:0] {
      CTRL_IDLE,
      CTRL_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
   } cfpq_cmd_type;

   typedef struct packed {
      logic             valid;
      logic [CLS_W-1:0] idx;
   } head_sel_type;

   // highest-numbered class with its bit set
   function automatic head_sel_type top_of(logic [NUM_CLASSES-1:0] nonempty);
      head_sel_type sel;
      sel.valid = 1'b0;
      sel.idx   = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (nonempty[c]) begin
            sel.valid = 1'b1;
            sel.idx   = CLS_W'(c);
         end
      end
      return sel;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] entry_addr(logic [CLS_W-1:0] c,
                                                     logic [PTR_W-1:0] p);
      return ADDR_W'(int'(c) * CLASS_DEPTH + int'(p));
   endfunction

   function automatic logic [DATA_WIDTH-1:0] word_from_field(logic [DATA_FW-1:0] f);
      logic [63:0] t;
      t = 64'(f);
      return t[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [DATA_FW-1:0] field_from_word(logic [DATA_WIDTH-1:0] w);
      logic [63:0] t;
      t = 64'(w);
      return t[DATA_FW-1:0];
   endfunction

   function automatic logic [CLS_W-1:0] cls_from_field(logic [CLASS_FW-1:0] f);
      logic [31:0] t;
      t = 32'(f);
      return t[CLS_W-1:0];
   endfunction

   function automatic logic [CLASS_FW-1:0] field_from_cls(logic [CLS_W-1:0] c);
      logic [31:0] t;
      t = 32'(c);
      return t[CLASS_FW-1:0];
   endfunction

   function automatic logic [COUNT_FW-1:0] field_from_total(logic [TOTAL_W-1:0] n);
      logic [31:0] t;
      t = 32'(n);
      return t[COUNT_FW-1:0];
   endfunction

endpackage

FILE: hw/rtl/class_fifo_priority_queue_unit.sv
// class_fifo_priority_queue_unit: top level of the class fifo priority queue
// depends on cfpq_pkg, cfpq_ctrl and cfpq_datapath
//
// usage
//   req channel carries one operation per transaction: insert (mode 0) appends
//   req_item_data to the fifo of req_class_index; remove (mode 1) takes the front
//   entry of the highest-numbered nonempty class
//   rsp channel returns one result per request: status, removed word, the new
//   head (valid, class, data) and the total number of entries held
//   an accepted request has its result registered and valid in the next cycle
//   one transaction at a time: the controller holds the next
//   request until the result is taken, so the entry store is touched once per op
//   the head read goes through the store's second read port in the same cycle as
//   the update, with a bypass when a fresh insert becomes the head
//   a stalled receiver holds the result registers and keeps req_ready low
//   reset clears all fill counts, pointers and the entry total; the entry store
//   itself is not cleared, only written entries are ever reported
//   insert into a full class answers status 1, remove from an empty queue status 2
module class_fifo_priority_queue_unit
   import cfpq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MODE_FW-1:0]   req_mode,
   input  logic [CLASS_FW-1:0]  req_class_index,
   input  logic [DATA_FW-1:0]   req_item_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_FW-1:0] rsp_status,
   output logic [DATA_FW-1:0]   rsp_removed_data,
   output logic                 rsp_head_valid,
   output logic [CLASS_FW-1:0]  rsp_head_class,
   output logic [DATA_FW-1:0]   rsp_head_data,
   output logic [COUNT_FW-1:0]  rsp_total_count
);

   // command from the controller: accept the current request transaction
   cfpq_cmd_type cmd;

   // handshake sequencing
   cfpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // queue state, entry store and result registers
   cfpq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_mode),
      .req_class_index  (req_class_index),
      .req_item_data    (req_item_data),
      .rsp_status       (rsp_status),
      .rsp_removed_data (rsp_removed_data),
      .rsp_head_valid   (rsp_head_valid),
      .rsp_head_class   (rsp_head_class),
      .rsp_head_data    (rsp_head_data),
      .rsp_total_count  (rsp_total_count)
   );

`ifndef ASSERT_OFF
   // only one transaction in flight: no request taken while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while result pending");

   // every accepted request yields a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no result after accepted request");

   // a remove from an empty queue reports nothing held
   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY)) |->
         (rsp_removed_data == '0) && !rsp_head_valid && (rsp_total_count == '0))
      else $error("empty remove reports data or entries");
`endif

endmodule

FILE: hw/rtl/cfpq_ctrl.sv
// cfpq_ctrl: handshake controller, one transaction in flight at a time
// depends on cfpq_pkg
module cfpq_ctrl
   import cfpq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output cfpq_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.accept = 1'b0;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = CTRL_RESP;
            end
         end
         CTRL_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/cfpq_datapath.sv
// cfpq_datapath: per-class pointers and fill counts, entry store, head lookup, result registers
// depends on cfpq_pkg
module cfpq_datapath
   import cfpq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfpq_cmd_type         cmd,
   input  logic [MODE_FW-1:0]   req_mode,
   input  logic [CLASS_FW-1:0]  req_class_index,
   input  logic [DATA_FW-1:0]   req_item_data,
   output logic [STATUS_FW-1:0] rsp_status,
   output logic [DATA_FW-1:0]   rsp_removed_data,
   output logic                 rsp_head_valid,
   output logic [CLASS_FW-1:0]  rsp_head_class,
   output logic [DATA_FW-1:0]   rsp_head_data,
   output logic [COUNT_FW-1:0]  rsp_total_count
);

   logic [FILL_W-1:0]  fill_ff [NUM_CLASSES];
   logic [FILL_W-1:0]  fill_in [NUM_CLASSES];
   logic [PTR_W-1:0]   rp_ff   [NUM_CLASSES];
   logic [PTR_W-1:0]   rp_in   [NUM_CLASSES];
   logic [PTR_W-1:0]   wp_ff   [NUM_CLASSES];
   logic [PTR_W-1:0]   wp_in   [NUM_CLASSES];
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic [DATA_WIDTH-1:0] store [STORE_DEPTH];

   logic [DATA_WIDTH-1:0] rem_data_ff, head_data_ff;
   logic [STATUS_FW-1:0]  status_ff, status_in;
   logic                  rem_ok_ff;
   logic                  head_valid_ff;
   logic [CLS_W-1:0]      head_class_ff;

   logic [CLS_W-1:0]       cls;
   logic                   cls_ok, ins_ok, rem_ok, fwd;
   logic [NUM_CLASSES-1:0] nonempty_now, nonempty_next;
   head_sel_type           top_now, top_next;
   logic [DATA_WIDTH-1:0]  word;
   logic [ADDR_W-1:0]      wr_addr, rem_addr, head_addr;

   always_comb begin
      cls    = cls_from_field(req_class_index);
      cls_ok = 32'(req_class_index) < NUM_CLASSES;
      word   = word_from_field(req_item_data);
      for (int c = 0; c < NUM_CLASSES; c++) begin
         nonempty_now[c] = fill_ff[c] != '0;
      end
      top_now = top_of(nonempty_now);
      ins_ok  = (req_mode == MODE_INSERT) && cls_ok && (fill_ff[cls] < FILL_W'(CLASS_DEPTH));
      rem_ok  = (req_mode == MODE_REMOVE) && top_now.valid;

      fill_in  = fill_ff;
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      total_in = total_ff;
      if (ins_ok) begin
         fill_in[cls] = fill_ff[cls] + 1'b1;
         wp_in[cls]   = ptr_next(wp_ff[cls]);
         total_in     = total_ff + 1'b1;
      end
      if (rem_ok) begin
         fill_in[top_now.idx] = fill_ff[top_now.idx] - 1'b1;
         rp_in[top_now.idx]   = ptr_next(rp_ff[top_now.idx]);
         total_in             = total_ff - 1'b1;
      end

      if (req_mode == MODE_INSERT) begin
         status_in = ins_ok ? STATUS_OK : STATUS_FULL;
      end else begin
         status_in = rem_ok ? STATUS_OK : STATUS_EMPTY;
      end

      for (int c = 0; c < NUM_CLASSES; c++) begin
         nonempty_next[c] = fill_in[c] != '0;
      end
      top_next  = top_of(nonempty_next);
      wr_addr   = entry_addr(cls, wp_ff[cls]);
      rem_addr  = entry_addr(top_now.idx, rp_ff[top_now.idx]);
      head_addr = entry_addr(top_next.idx, rp_in[top_next.idx]);
      // a fresh insert into an empty class can become the head in the same cycle
      fwd       = ins_ok && (head_addr == wr_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            fill_ff[c] <= '0;
            rp_ff[c]   <= '0;
            wp_ff[c]   <= '0;
         end
         total_ff <= '0;
      end else if (cmd.accept) begin
         fill_ff  <= fill_in;
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         total_ff <= total_in;
      end
   end

   // entry store, one write port and two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.accept && ins_ok) begin
         store[wr_addr] <= word;
      end
      if (cmd.accept) begin
         rem_data_ff  <= store[rem_addr];
         head_data_ff <= fwd ? word : store[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_ff     <= status_in;
         rem_ok_ff     <= rem_ok;
         head_valid_ff <= top_next.valid;
         head_class_ff <= top_next.idx;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_removed_data = rem_ok_ff ? field_from_word(rem_data_ff) : '0;
   assign rsp_head_valid   = head_valid_ff;
   assign rsp_head_class   = head_valid_ff ? field_from_cls(head_class_ff) : '0;
   assign rsp_head_data    = head_valid_ff ? field_from_word(head_data_ff) : '0;
   assign rsp_total_count  = field_from_total(total_ff);

`ifndef ASSERT_OFF
   // a remove can never leave more entries than before
   a_remove_no_growth: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && rem_ok) |=> (total_ff < total_ff + 1'b1) && (total_ff == $past(total_ff) - 1'b1))
      else $error("remove did not decrement entry total");

   // a dropped transaction leaves the entry total alone
   a_drop_keeps_total: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !ins_ok && !rem_ok) |=> $stable(total_ff))
      else $error("dropped transaction changed entry total");

   // the head exists exactly when the queue holds entries
   a_head_matches_total: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.accept) |-> (head_valid_ff == (total_ff != '0)))
      else $error("head valid disagrees with entry total");
`endif

endmodule
